FILE: design/chm_pkg.sv
// chm_pkg: shared types, codes and defaults for the chained hash multiset
// no dependencies
`default_nettype none

package chm_pkg;

    localparam int KEY_W       = 32;
    localparam int BUCKETS_DEF = 97;
    localparam int WAYS_DEF    = 4;
    localparam int KEYBITS_DEF = 32;
    localparam int Q_DEPTH     = 4;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
    } s_item_t;

    typedef struct packed {
        logic       found;
        logic [1:0] status;
    } m_item_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // stored key width: key bits above this are dropped
    function automatic int eff_key_w(input int key_bits);
        return (key_bits > KEY_W) ? KEY_W : key_bits;
    endfunction

endpackage

`default_nettype wire

FILE: design/chm_front.sv
// chm_front: accepts items, trims the key and computes key mod BUCKETS
// depends on chm_pkg
`default_nettype none

module chm_front #(
    parameter int BUCKETS  = chm_pkg::BUCKETS_DEF,
    parameter int KEY_BITS = chm_pkg::KEYBITS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  chm_pkg::s_item_t     s_item,
    input  wire                  clearing,
    input  chm_pkg::qstat_t      qstat,
    output logic                 push,
    output logic [2+chm_pkg::eff_key_w(KEY_BITS)+$clog2(BUCKETS)-1:0] push_data
);

    localparam int KW    = chm_pkg::eff_key_w(KEY_BITS);
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int CW    = ((KW > BKT_W) ? KW : BKT_W) + 1;
    localparam logic [63:0]   RECIP_FULL = (64'd1 << KW) / 64'(BUCKETS);
    localparam logic [KW-1:0] RECIP      = RECIP_FULL[KW-1:0];

    logic              v1_reg, v2_reg, v3_reg;
    logic [1:0]        cmd1_reg, cmd2_reg, cmd3_reg;
    logic [KW-1:0]     key1_reg, key2_reg, key3_reg;
    logic [2*KW-1:0]   prod1_reg;
    logic [KW-1:0]     qb2_reg;
    logic [BKT_W-1:0]  bkt3_reg;

    logic              adv;
    logic              s_fire;
    logic [KW-1:0]     key_m;
    logic [2*KW-1:0]   prod_next;
    logic [KW-1:0]     qb_next;
    logic [CW-1:0]     rem_c;
    logic [CW-1:0]     rem_fix;

    assign adv     = !v3_reg || !qstat.full;
    assign s_ready = adv && !clearing;
    assign s_fire  = s_valid && s_ready;
    assign key_m   = s_item.key[KW-1:0];

    // quotient estimate by reciprocal, low by at most one
    assign prod_next = (2*KW)'(key_m) * (2*KW)'(RECIP);
    assign qb_next   = KW'(prod1_reg[2*KW-1:KW]) * KW'(BUCKETS);

    always_comb begin
        rem_c   = CW'(key2_reg) - CW'(qb2_reg);
        rem_fix = rem_c;
        if (rem_c >= CW'(BUCKETS)) begin
            rem_fix = rem_c - CW'(BUCKETS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cmd1_reg  <= s_item.command;
            key1_reg  <= key_m;
            prod1_reg <= prod_next;
            cmd2_reg  <= cmd1_reg;
            key2_reg  <= key1_reg;
            qb2_reg   <= qb_next;
            cmd3_reg  <= cmd2_reg;
            key3_reg  <= key2_reg;
            bkt3_reg  <= rem_fix[BKT_W-1:0];
        end
    end

    assign push      = v3_reg && !qstat.full;
    assign push_data = {cmd3_reg, key3_reg, bkt3_reg};

endmodule

`default_nettype wire

FILE: design/chm_queue.sv
// chm_queue: short fifo between the front and the back
// depends on chm_pkg
`default_nettype none

module chm_queue #(
    parameter int W = 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  wire  [W-1:0]     push_data,
    input  wire              pop,
    output logic [W-1:0]     head,
    output chm_pkg::qstat_t  qstat
);

    localparam int PW = $clog2(chm_pkg::Q_DEPTH);

    logic [W-1:0]  ent_reg [chm_pkg::Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   cnt_reg;
    logic          do_push, do_pop;

    assign qstat.full  = (cnt_reg == (PW+1)'(chm_pkg::Q_DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/chm_back.sv
// chm_back: bucket memory, clear pass and read-modify-write of one bucket row
// depends on chm_pkg
`default_nettype none

module chm_back #(
    parameter int BUCKETS  = chm_pkg::BUCKETS_DEF,
    parameter int WAYS     = chm_pkg::WAYS_DEF,
    parameter int KEY_BITS = chm_pkg::KEYBITS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  chm_pkg::qstat_t      qstat,
    input  wire  [2+chm_pkg::eff_key_w(KEY_BITS)+$clog2(BUCKETS)-1:0] head,
    output logic                 pop,
    output logic                 clearing,
    output logic                 m_valid,
    input  wire                  m_ready,
    output chm_pkg::m_item_t     m_item
);

    localparam int KW    = chm_pkg::eff_key_w(KEY_BITS);
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int ROW_W = WAYS * (KW + 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    // row: keys above, valid marks in the low WAYS bits
    logic [ROW_W-1:0] mem [BUCKETS];

    logic [1:0]        st_reg, st_next;
    logic [BKT_W-1:0]  clr_cnt_reg;
    logic [1:0]        cmd_reg;
    logic [KW-1:0]     key_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [ROW_W-1:0]  rd_row_reg;
    logic              m_valid_reg;
    chm_pkg::m_item_t  m_item_reg;

    logic [1:0]        h_cmd;
    logic [KW-1:0]     h_key;
    logic [BKT_W-1:0]  h_bkt;
    logic              done;
    logic              we;
    logic [BKT_W-1:0]  wr_addr;
    logic [ROW_W-1:0]  wr_row;

    logic [WAYS-1:0]   valid_v, match_v, free_v, ins_oh, del_oh, valid_new;
    logic [KW-1:0]     keys_v   [WAYS];
    logic [KW-1:0]     keys_new [WAYS];
    chm_pkg::m_item_t  res;

    assign h_bkt = head[BKT_W-1:0];
    assign h_key = head[BKT_W +: KW];
    assign h_cmd = head[BKT_W+KW +: 2];

    assign clearing = (st_reg == S_CLEAR);
    assign pop      = (st_reg == S_READ) && !qstat.empty;
    assign done     = (st_reg == S_WRITE) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    always_comb begin
        valid_v = rd_row_reg[WAYS-1:0];
        for (int w = 0; w < WAYS; w++) begin
            keys_v[w]  = rd_row_reg[WAYS + w*KW +: KW];
            match_v[w] = valid_v[w] && (keys_v[w] == key_reg);
            free_v[w]  = !valid_v[w];
        end
        // lowest set bit
        ins_oh = free_v & (~free_v + 1'b1);
        del_oh = match_v & (~match_v + 1'b1);

        valid_new  = valid_v;
        res.found  = 1'b0;
        res.status = chm_pkg::STAT_OK;
        for (int w = 0; w < WAYS; w++) begin
            keys_new[w] = keys_v[w];
        end

        unique case (cmd_reg)
            chm_pkg::CMD_INSERT: begin
                if (|free_v) begin
                    valid_new = valid_v | ins_oh;
                    for (int w = 0; w < WAYS; w++) begin
                        if (ins_oh[w]) begin
                            keys_new[w] = key_reg;
                        end
                    end
                end else begin
                    res.status = chm_pkg::STAT_FULL;
                end
            end
            chm_pkg::CMD_DELETE: begin
                if (|match_v) begin
                    valid_new = valid_v & ~del_oh;
                    res.found = 1'b1;
                end else begin
                    res.status = chm_pkg::STAT_NOT_FOUND;
                end
            end
            chm_pkg::CMD_SEARCH: begin
                res.found = |match_v;
            end
            default: begin
                // unused command: no change, plain ok result
            end
        endcase

        wr_row = '0;
        wr_row[WAYS-1:0] = valid_new;
        for (int w = 0; w < WAYS; w++) begin
            wr_row[WAYS + w*KW +: KW] = keys_new[w];
        end
    end

    assign we      = clearing || done;
    assign wr_addr = clearing ? clr_cnt_reg : bkt_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == BKT_W'(BUCKETS - 1)) begin
                    st_next = S_READ;
                end
            end
            S_READ: begin
                if (pop) begin
                    st_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (done) begin
                    st_next = S_READ;
                end
            end
            default: begin
                st_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= S_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= h_cmd;
            key_reg <= h_key;
            bkt_reg <= h_bkt;
        end
        if (done) begin
            m_item_reg <= res;
        end
    end

    // bucket memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= clearing ? '0 : wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_row_reg <= mem[h_bkt];
        end
    end

endmodule

`default_nettype wire

FILE: design/chained_hash_multiset.sv
// chained_hash_multiset: top level, front / queue / back
// depends on chm_pkg, chm_front, chm_queue, chm_back
//
//  port group   dir  handshake          payload
//  s_*          in   s_valid/s_ready    s_item (command, key)
//  m_*          out  m_valid/m_ready    m_item (found, status)
//
// the back handles one item at a time: bucket row read, then modify and write back
// the front is pipelined: reciprocal multiply, quotient times BUCKETS, fix-up
// after reset a clear pass zeroes the valid marks of every bucket; s_ready is low
// a held result in the output register stalls the back, a full queue stalls the front
`default_nettype none

module chained_hash_multiset #(
    parameter int BUCKETS  = chm_pkg::BUCKETS_DEF,
    parameter int WAYS     = chm_pkg::WAYS_DEF,
    parameter int KEY_BITS = chm_pkg::KEYBITS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  chm_pkg::s_item_t  s_item,
    output logic              m_valid,
    input  wire               m_ready,
    output chm_pkg::m_item_t  m_item
);

    localparam int QW = 2 + chm_pkg::eff_key_w(KEY_BITS) + $clog2(BUCKETS);

    chm_pkg::qstat_t qstat;
    logic            push, pop, clearing;
    logic [QW-1:0]   push_data, head;

    chm_front #(
        .BUCKETS  (BUCKETS),
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .clearing  (clearing),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    chm_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    chm_back #(
        .BUCKETS  (BUCKETS),
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

`default_nettype wire

FILE: design/chm_checker.sv
// chm_checker: port-level assertions for chained_hash_multiset, bound to the top
// depends on chm_pkg, chained_hash_multiset
`default_nettype none

module chm_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               s_valid,
    input wire               s_ready,
    input chm_pkg::s_item_t  s_item,
    input wire               m_valid,
    input wire               m_ready,
    input chm_pkg::m_item_t  m_item
);

    // an offered item holds until taken
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input item changed while waiting");

    // a waiting result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.status == chm_pkg::STAT_OK ||
                     m_item.status == chm_pkg::STAT_NOT_FOUND ||
                     m_item.status == chm_pkg::STAT_FULL))
        else $error("unused status code");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.found |-> m_item.status == chm_pkg::STAT_OK)
        else $error("found with error status");

    // clear pass blocks input right after reset
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready && !m_valid)
        else $error("item taken during clear pass");

endmodule

bind chained_hash_multiset chm_checker u_chm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
